// File: src/assert_macros.svh
// assertion macros shared by the curve lookup modules
// expects i_clk and i_rst_n in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PLCL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define PLCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/plcl_pkg.sv
// package for the piecewise-linear curve lookup
// operation and status codes, transaction payload types; no dependencies
`timescale 1ns / 1ps

package plcl_pkg;

    // operation codes
    localparam logic [1:0] OP_WR_BREAK  = 2'd0;
    localparam logic [1:0] OP_WR_SAMPLE = 2'd1;
    localparam logic [1:0] OP_QUERY     = 2'd2;

    // number of valid curve kinds (transmission, scatter, specular)
    localparam int CURVE_KINDS = 3;

    // result status codes
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_INVALID = 1'b1;

    // input transaction payload
    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  material;
        logic [1:0]  curve;
        logic [3:0]  sample_index;
        logic [15:0] angle;
        logic [15:0] sample_value;
    } t_in_item;

    // result transaction payload
    typedef struct packed {
        logic [15:0] result_value;
        logic        status;
    } t_out_item;

endpackage

// File: src/plcl_stream_if.sv
// valid/ready stream channel used for the lookup's input and result
// payload type set per instance; no other dependencies
`timescale 1ns / 1ps

interface plcl_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/plcl_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module plcl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/plcl_div.sv
// restoring divider giving the q1.16 segment fraction, one quotient bit a cycle
// uses assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plcl_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [16:0] o_quot
);

    // quotient (num << 16) / den has 17 bits since num <= den
    localparam logic [4:0] LAST_STEP = 5'd16;

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [16:0] r_bits;
    logic [16:0] r_quot;
    logic [15:0] r_den;

    logic [16:0] trial;
    logic [16:0] trial_sub;
    logic        fits;

    // one compare and subtract per step
    assign trial     = {r_rem, r_bits[16]};
    assign trial_sub = trial - {1'b0, r_den};
    assign fits      = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == LAST_STEP) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath: remainder starts as the dividend's bits above the quotient range
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num[15:1]};
            r_bits <= {i_num[0], 16'b0};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? trial_sub[15:0] : trial[15:0];
            r_bits <= {r_bits[15:0], 1'b0};
            r_quot <= {r_quot[15:0], fits};
        end
    end

    assign o_done = r_busy && (r_cnt == LAST_STEP);
    assign o_quot = r_quot;

    // checks
    `PLCL_ASSERT_NOW(a_den_nonzero, i_start, i_den != 16'd0, "divide by zero started")
    `PLCL_ASSERT_NOW(a_num_in_range, i_start, i_num <= i_den, "fraction above one")
    `PLCL_ASSERT_NEXT(a_quot_max, o_done, r_quot <= 17'h10000, "quotient above one")

endmodule

// File: src/piecewise_linear_curve_lookup.sv
// Piecewise-linear curve lookup, top level.
// Input channel i_item carries one transaction per item: operation 0 writes
// a breakpoint, 1 writes a sample of one material and curve, 2 is a query.
// Writes are taken one per cycle while the sequencer is idle and produce no
// result. A query produces one transaction on o_result: the interpolated
// Q1.15 value and a status bit (invalid material or curve gives value zero
// with status set). A query runs on a small sequencer: one breakpoint read
// per cycle in the segment search, then the restoring divider (one quotient
// bit per step), two sample reads and a multiply-add; a clamp or a flat
// segment skips the divider and takes one sample read. An invalid query goes
// straight to the output register; the search length and the divider set
// how long a query takes. The next item is taken the cycle after the result
// register loads. i_item is not ready while a query is in progress. The
// result sits in an output register, so the next item is accepted while a
// result is still waiting; a stalled receiver holds the block only when a
// second result is ready to leave. Reset (i_rst_n, synchronous, active low)
// empties the sequencer and the output register; the stores are not cleared
// and an entry must be written before a query reads it.
// Depends on plcl_pkg, plcl_stream_if, plcl_ram, plcl_div, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module piecewise_linear_curve_lookup #(
    parameter int SAMPLES   = 16,
    parameter int MATERIALS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    plcl_stream_if.sink    i_item,
    plcl_stream_if.source  o_result
);

    localparam int BAW       = $clog2(SAMPLES);
    localparam int IW        = $clog2(SAMPLES + 1);
    localparam int SMP_DEPTH = MATERIALS * plcl_pkg::CURVE_KINDS * SAMPLES;
    localparam int SAW       = $clog2(SMP_DEPTH);

    // sequencer states
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LAST = 9'b000000010,
        S_SCAN = 9'b000000100,
        S_DIV  = 9'b000001000,
        S_SMP0 = 9'b000010000,
        S_SMP1 = 9'b000100000,
        S_MUL  = 9'b001000000,
        S_ADD  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    logic [IW-1:0]      r_idx, n_idx;
    logic [15:0]        r_angle, n_angle;
    logic [SAW-1:0]     r_base, n_base;
    logic [15:0]        r_prev, n_prev;
    logic [BAW-1:0]     r_seg, n_seg;
    logic               r_direct, n_direct;
    logic               r_above, n_above;
    logic [15:0]        r_s0, n_s0;
    logic [15:0]        r_s1, n_s1;
    logic signed [34:0] r_prod, n_prod;
    logic [15:0]        r_result, n_result;
    logic               r_status, n_status;

    logic                r_out_valid;
    plcl_pkg::t_out_item r_out_data;

    plcl_pkg::t_in_item in_data;
    logic               in_acc;
    logic               idx_ok;
    logic               query_ok;
    logic [SAW-1:0]     in_base;

    logic [BAW-1:0] bp_raddr;
    logic [15:0]    bp_rdata;
    logic           bp_we;
    logic [SAW-1:0] smp_raddr;
    logic [SAW-1:0] smp_waddr;
    logic [15:0]    smp_rdata;
    logic           smp_we;

    logic           div_start;
    logic           div_done;
    logic [16:0]    div_quot;

    logic [IW-1:0]      scan_k;
    logic signed [16:0] blend_diff;
    logic signed [17:0] blend_u;
    logic signed [34:0] blend_acc;
    logic [15:0]        blend_val;
    logic               out_load;

    // input decode
    assign in_data  = i_item.data;
    assign i_item.ready = (r_state == S_IDLE);
    assign in_acc   = i_item.valid && i_item.ready;
    assign idx_ok   = (32'(in_data.sample_index) < SAMPLES);
    assign query_ok = (32'(in_data.material) < MATERIALS) &&
                      (32'(in_data.curve) < plcl_pkg::CURVE_KINDS);
    assign in_base  = SAW'((32'(in_data.material) * plcl_pkg::CURVE_KINDS
                            + 32'(in_data.curve)) * SAMPLES);

    // breakpoint store: last entry is read first, then a forward scan
    assign bp_we    = in_acc && (in_data.operation == plcl_pkg::OP_WR_BREAK) && idx_ok;
    assign bp_raddr = (r_state == S_IDLE) ? BAW'(SAMPLES - 1) : r_idx[BAW-1:0];

    plcl_ram #(
        .WIDTH (16),
        .DEPTH (SAMPLES)
    ) u_bp_ram (
        .i_clk   (i_clk),
        .i_we    (bp_we),
        .i_waddr (BAW'(in_data.sample_index)),
        .i_wdata (in_data.angle),
        .i_raddr (bp_raddr),
        .o_rdata (bp_rdata)
    );

    // sample store, indexed by (material * 3 + curve) * SAMPLES + index
    assign smp_we    = in_acc && (in_data.operation == plcl_pkg::OP_WR_SAMPLE) &&
                       query_ok && idx_ok;
    assign smp_waddr = in_base + SAW'(in_data.sample_index);
    assign smp_raddr = r_base + SAW'(r_seg) +
                       SAW'(((r_state == S_SMP1) && !r_direct) ? 1 : 0);

    plcl_ram #(
        .WIDTH (16),
        .DEPTH (SMP_DEPTH)
    ) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (smp_we),
        .i_waddr (smp_waddr),
        .i_wdata (in_data.sample_value),
        .i_raddr (smp_raddr),
        .o_rdata (smp_rdata)
    );

    // divider for the segment fraction
    plcl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_angle - r_prev),
        .i_den   (bp_rdata - r_prev),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // blend: s0 + (s1 - s0) * u, rounded half up
    assign blend_diff = $signed({1'b0, smp_rdata} - {1'b0, r_s0});
    assign blend_u    = $signed({1'b0, div_quot});
    assign blend_acc  = $signed({3'b0, r_s0, 16'b0}) + r_prod + 35'sd32768;
    assign blend_val  = blend_acc[31:16];

    // position of the breakpoint now on the read data
    assign scan_k = r_idx - IW'(1);

    assign out_load = (r_state == S_OUT) && (!r_out_valid || o_result.ready);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_angle   = r_angle;
        n_base    = r_base;
        n_prev    = r_prev;
        n_seg     = r_seg;
        n_direct  = r_direct;
        n_above   = r_above;
        n_s0      = r_s0;
        n_s1      = r_s1;
        n_prod    = r_prod;
        n_result  = r_result;
        n_status  = r_status;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (in_data.operation == plcl_pkg::OP_QUERY)) begin
                    n_angle = in_data.angle;
                    n_base  = in_base;
                    n_idx   = '0;
                    if (query_ok) begin
                        n_state = S_LAST;
                    end else begin
                        n_result = '0;
                        n_status = plcl_pkg::ST_INVALID;
                        n_state  = S_OUT;
                    end
                end
            end
            S_LAST: begin
                // note the upper clamp; the lower clamp on the first breakpoint wins
                n_above = (r_angle >= bp_rdata);
                n_idx   = r_idx + IW'(1);
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (scan_k == '0) begin
                    if (r_angle <= bp_rdata) begin
                        n_seg    = '0;
                        n_direct = 1'b1;
                        n_state  = S_SMP0;
                    end else if (r_above) begin
                        n_seg    = BAW'(SAMPLES - 1);
                        n_direct = 1'b1;
                        n_state  = S_SMP0;
                    end else begin
                        n_prev = bp_rdata;
                        n_idx  = r_idx + IW'(1);
                    end
                end else if ((r_angle >= r_prev) && (r_angle <= bp_rdata)) begin
                    n_seg = BAW'(scan_k - IW'(1));
                    if (bp_rdata == r_prev) begin
                        // flat segment: lower sample, no division
                        n_direct = 1'b1;
                        n_state  = S_SMP0;
                    end else begin
                        n_direct  = 1'b0;
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end else if (scan_k == IW'(SAMPLES - 1)) begin
                    // no enclosing segment: last sample
                    n_seg    = BAW'(SAMPLES - 1);
                    n_direct = 1'b1;
                    n_state  = S_SMP0;
                end else begin
                    n_prev = bp_rdata;
                    n_idx  = r_idx + IW'(1);
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_SMP0;
                end
            end
            S_SMP0: begin
                n_state = S_SMP1;
            end
            S_SMP1: begin
                if (r_direct) begin
                    n_result = smp_rdata;
                    n_status = plcl_pkg::ST_OK;
                    n_state  = S_OUT;
                end else begin
                    n_s0    = smp_rdata;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_s1    = smp_rdata;
                n_prod  = blend_diff * blend_u;
                n_state = S_ADD;
            end
            S_ADD: begin
                n_result = blend_val;
                n_status = plcl_pkg::ST_OK;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_angle  <= n_angle;
        r_base   <= n_base;
        r_prev   <= n_prev;
        r_seg    <= n_seg;
        r_direct <= n_direct;
        r_above  <= n_above;
        r_s0     <= n_s0;
        r_s1     <= n_s1;
        r_prod   <= n_prod;
        r_result <= n_result;
        r_status <= n_status;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data.result_value <= r_result;
            r_out_data.status       <= r_status;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

    // checks
    `PLCL_ASSERT_NOW(a_invalid_zero, r_out_valid && (r_out_data.status == plcl_pkg::ST_INVALID),
        r_out_data.result_value == 16'd0, "invalid query with nonzero value")
    `PLCL_ASSERT_NOW(a_blend_bounded, r_state == S_ADD,
        ((blend_val >= r_s0) && (blend_val <= r_s1)) ||
        ((blend_val >= r_s1) && (blend_val <= r_s0)), "blend outside its samples")
    `PLCL_ASSERT_NEXT(a_div_finishes, (r_state == S_DIV) && div_done,
        r_state == S_SMP0, "divider result not consumed")
    `PLCL_ASSERT_NOW(a_busy_not_ready, (r_state != S_IDLE), !i_item.ready,
        "input taken during a query")

endmodule
